// ===== rtl/ustcd_pkg.sv =====
// Package for the Unix seconds to calendar date converter.
// Holds the result and handshake types, divisor constants and the month length table.
// No dependencies.
package ustcd_pkg;

  localparam logic [11:0] FIRST_YEAR = 12'd1970;
  localparam logic [1:0]  FIRST_MOD4 = 2'd2;
  localparam logic [6:0]  FIRST_MOD100 = 7'd70;
  localparam logic [8:0]  FIRST_MOD400 = 9'd370;
  localparam logic [6:0]  LAST_MOD100 = 7'd99;
  localparam logic [8:0]  LAST_MOD400 = 9'd399;

  localparam logic [8:0] YEAR_DAYS = 9'd365;
  localparam logic [8:0] LEAP_YEAR_DAYS = 9'd366;

  localparam int DAY_STEPS = 16;
  localparam int HOUR_STEPS = 5;
  localparam int MIN_STEPS = 6;

  localparam logic [31:0] DAY_DIVISOR = 32'(64'd86400 << (DAY_STEPS - 1));
  localparam logic [31:0] HOUR_DIVISOR = 32'(64'd3600 << (HOUR_STEPS - 1));
  localparam logic [31:0] MIN_DIVISOR = 32'(64'd60 << (MIN_STEPS - 1));

  localparam logic [3:0] LAST_MONTH = 4'd11;
  localparam logic [3:0] FEBRUARY = 4'd1;

  typedef struct packed {
    logic [4:0]  day_of_month;
    logic [3:0]  month_number;
    logic [11:0] year_number;
    logic [4:0]  hour_of_day;
    logic [5:0]  minute_of_hour;
    logic [5:0]  second_of_minute;
  } date_t;

  typedef struct packed {
    logic start;
    logic taken;
  } ctl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } status_t;

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd3:    len = 5'd30;
      4'd5:    len = 5'd30;
      4'd8:    len = 5'd30;
      4'd10:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/unix_seconds_to_calendar_date_top.sv =====
// Top level of the Unix seconds to calendar date converter.
// Holds the input handshake and the output word register; uses ustcd_seq and ustcd_pkg.
//
// Channel  Direction  Handshake           Word
// input    in         in_valid/in_stall   epoch_seconds
// output   out        out_valid/out_stall day_of_month .. second_of_minute
//
// Each accepted word passes through the day division, the year steps, the month steps, the hour
// division and the minute division before it is loaded into the output register, all on the one
// shared subtract and compare unit. The next word can be accepted in the cycle after that load.
// The input is stalled from acceptance until the result moves into the output register.
// A finished result waits in the sequencer while the output register is still held by a stall.
// Reset returns the sequencer to idle and empties the output register.
module unix_seconds_to_calendar_date_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] epoch_seconds,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  day_of_month,
  output logic [3:0]  month_number,
  output logic [11:0] year_number,
  output logic [4:0]  hour_of_day,
  output logic [5:0]  minute_of_hour,
  output logic [5:0]  second_of_minute
);

  ustcd_pkg::ctl_t    ctl;
  ustcd_pkg::status_t status;
  ustcd_pkg::date_t   result;
  ustcd_pkg::date_t   out_word;

  assign in_stall = ~status.idle;
  assign ctl.start = in_valid & status.idle;
  assign ctl.taken = status.done & (~out_valid | ~out_stall);

  ustcd_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .epoch_seconds (epoch_seconds),
    .status        (status),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.taken) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.taken) begin
      out_word <= result;
    end
  end

  assign day_of_month = out_word.day_of_month;
  assign month_number = out_word.month_number;
  assign year_number = out_word.year_number;
  assign hour_of_day = out_word.hour_of_day;
  assign minute_of_hour = out_word.minute_of_hour;
  assign second_of_minute = out_word.second_of_minute;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("sequencer not busy after accepting a word");

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (month_number >= 4'd1 && month_number <= 4'd12))
    else $error("month out of range");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hour_of_day < 5'd24 && minute_of_hour < 6'd60 && second_of_minute < 6'd60))
    else $error("time of day out of range");

  a_day_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (day_of_month >= 5'd1 && year_number >= 12'd1970 && year_number <= 12'd2106))
    else $error("day or year out of range");

endmodule

// ===== rtl/ustcd_sub.sv =====
// Shared subtract and compare unit of the date converter.
// Gives a minus b and whether a is at least b. No dependencies.
module ustcd_sub (
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] diff,
  output logic        ge
);

  logic [32:0] wide;

  assign wide = {1'b0, a} - {1'b0, b};
  assign diff = wide[31:0];
  assign ge = ~wide[32];

endmodule

// ===== rtl/ustcd_seq.sv =====
// Sequencer and working registers of the date converter.
// Drives the shared unit in ustcd_sub through division, year, month and time steps.
// Uses ustcd_pkg.
module ustcd_seq (
  input  logic                    clk,
  input  logic                    rst,
  input  ustcd_pkg::ctl_t         ctl,
  input  logic [31:0]             epoch_seconds,
  output ustcd_pkg::status_t      status,
  output ustcd_pkg::date_t        result
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV_DAY = 3'd1;
  localparam logic [2:0] ST_YEAR = 3'd2;
  localparam logic [2:0] ST_MONTH = 3'd3;
  localparam logic [2:0] ST_DIV_HOUR = 3'd4;
  localparam logic [2:0] ST_DIV_MIN = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [2:0]  state;
  logic [2:0]  state_next;
  logic [31:0] rem;
  logic [31:0] divisor;
  logic [15:0] quo;
  logic [3:0]  cnt;
  logic [11:0] year;
  logic [1:0]  mod4;
  logic [6:0]  mod100;
  logic [8:0]  mod400;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic        leap;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [31:0] diff;
  logic        ge;

  assign leap = (mod400 == 9'd0) || ((mod4 == 2'd0) && (mod100 != 7'd0));

  always_comb begin
    unique case (state)
      ST_YEAR: begin
        op_a = {16'd0, quo};
        op_b = {23'd0, leap ? ustcd_pkg::LEAP_YEAR_DAYS : ustcd_pkg::YEAR_DAYS};
      end
      ST_MONTH: begin
        op_a = {16'd0, quo};
        op_b = {27'd0, ustcd_pkg::month_len(month, leap)};
      end
      default: begin
        op_a = rem;
        op_b = divisor;
      end
    endcase
  end

  ustcd_sub u_sub (
    .a    (op_a),
    .b    (op_b),
    .diff (diff),
    .ge   (ge)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (ctl.start) state_next = ST_DIV_DAY;
      ST_DIV_DAY:  if (cnt == 4'd0) state_next = ST_YEAR;
      ST_YEAR:     if (!ge) state_next = ST_MONTH;
      ST_MONTH:    if (month == ustcd_pkg::LAST_MONTH || !ge) state_next = ST_DIV_HOUR;
      ST_DIV_HOUR: if (cnt == 4'd0) state_next = ST_DIV_MIN;
      ST_DIV_MIN:  if (cnt == 4'd0) state_next = ST_DONE;
      ST_DONE:     if (ctl.taken) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (ctl.start) begin
          rem <= epoch_seconds;
          divisor <= ustcd_pkg::DAY_DIVISOR;
          cnt <= 4'(ustcd_pkg::DAY_STEPS - 1);
          quo <= 16'd0;
          year <= ustcd_pkg::FIRST_YEAR;
          mod4 <= ustcd_pkg::FIRST_MOD4;
          mod100 <= ustcd_pkg::FIRST_MOD100;
          mod400 <= ustcd_pkg::FIRST_MOD400;
          month <= 4'd0;
        end
      end
      ST_DIV_DAY: begin
        if (ge) rem <= diff;
        quo <= {quo[14:0], ge};
        divisor <= {1'b0, divisor[31:1]};
        cnt <= cnt - 4'd1;
      end
      ST_YEAR: begin
        if (ge) begin
          quo <= diff[15:0];
          year <= year + 12'd1;
          mod4 <= mod4 + 2'd1;
          mod100 <= (mod100 == ustcd_pkg::LAST_MOD100) ? 7'd0 : mod100 + 7'd1;
          mod400 <= (mod400 == ustcd_pkg::LAST_MOD400) ? 9'd0 : mod400 + 9'd1;
        end
      end
      ST_MONTH: begin
        if (month != ustcd_pkg::LAST_MONTH && ge) begin
          quo <= diff[15:0];
          month <= month + 4'd1;
        end else begin
          day <= quo[4:0] + 5'd1;
          divisor <= ustcd_pkg::HOUR_DIVISOR;
          cnt <= 4'(ustcd_pkg::HOUR_STEPS - 1);
          quo <= 16'd0;
        end
      end
      ST_DIV_HOUR: begin
        if (ge) rem <= diff;
        if (cnt == 4'd0) begin
          hour <= {quo[3:0], ge};
          divisor <= ustcd_pkg::MIN_DIVISOR;
          cnt <= 4'(ustcd_pkg::MIN_STEPS - 1);
          quo <= 16'd0;
        end else begin
          quo <= {quo[14:0], ge};
          divisor <= {1'b0, divisor[31:1]};
          cnt <= cnt - 4'd1;
        end
      end
      ST_DIV_MIN: begin
        if (ge) rem <= diff;
        if (cnt == 4'd0) begin
          minute <= {quo[4:0], ge};
        end else begin
          quo <= {quo[14:0], ge};
          divisor <= {1'b0, divisor[31:1]};
          cnt <= cnt - 4'd1;
        end
      end
      default: begin
      end
    endcase
  end

  assign status.idle = (state == ST_IDLE);
  assign status.done = (state == ST_DONE);

  assign result.day_of_month = day;
  assign result.month_number = month + 4'd1;
  assign result.year_number = year;
  assign result.hour_of_day = hour;
  assign result.minute_of_hour = minute;
  assign result.second_of_minute = rem[5:0];

endmodule

// ===== verif/unix_seconds_to_calendar_date_top_test.sv =====
// Testbench for unix_seconds_to_calendar_date_top: drives timestamps, predicts each calendar date
// and checks every output word in order. Depends on ustcd_pkg and the top level only.
`timescale 1ns / 100ps

module unix_seconds_to_calendar_date_top_test;

  localparam int unsigned SECS_PER_DAY = 86400;
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 200;

  typedef struct {
    logic [31:0]      secs;
    ustcd_pkg::date_t date;
  } conversion_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] epoch_seconds;
  logic        out_valid;
  logic        out_stall;
  logic [4:0]  day_of_month;
  logic [3:0]  month_number;
  logic [11:0] year_number;
  logic [4:0]  hour_of_day;
  logic [5:0]  minute_of_hour;
  logic [5:0]  second_of_minute;

  conversion_t dates_due[$];
  int          mismatch_count;
  bit          idling_on;
  bit          hold_request;

  unix_seconds_to_calendar_date_top dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .epoch_seconds(epoch_seconds),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .day_of_month(day_of_month),
    .month_number(month_number),
    .year_number(year_number),
    .hour_of_day(hour_of_day),
    .minute_of_hour(minute_of_hour),
    .second_of_minute(second_of_minute)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit is_leap_year(input int unsigned yr);
    return (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
  endfunction

  function automatic ustcd_pkg::date_t calendar_of(input logic [31:0] secs);
    ustcd_pkg::date_t d;
    int unsigned      days;
    int unsigned      tod;
    int unsigned      yr;
    int unsigned      mon;
    int unsigned      span;
    bit               found;
    days = secs / SECS_PER_DAY;
    tod = secs % SECS_PER_DAY;
    yr = 1970;
    span = 365 + int'(is_leap_year(yr));
    while (days >= span) begin
      days -= span;
      yr++;
      span = 365 + int'(is_leap_year(yr));
    end
    mon = 0;
    found = 1'b0;
    while (mon < ustcd_pkg::LAST_MONTH && !found) begin
      if (mon == ustcd_pkg::FEBRUARY) begin
        span = is_leap_year(yr) ? 29 : 28;
      end else if (mon == 3 || mon == 5 || mon == 8 || mon == 10) begin
        span = 30;
      end else begin
        span = 31;
      end
      if (days < span) begin
        found = 1'b1;
      end else begin
        days -= span;
        mon++;
      end
    end
    d.day_of_month = 5'(days + 1);
    d.month_number = 4'(mon + 1);
    d.year_number = 12'(yr);
    d.hour_of_day = 5'(tod / 3600);
    d.minute_of_hour = 6'((tod % 3600) / 60);
    d.second_of_minute = 6'(tod % 60);
    return d;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] secs,
                             input logic [31:0] got, input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s for input %0d: got %0d, expected %0d",
                                name, secs, got, want));
    end
  endtask

  // Offers one word, with an optional idle burst first, and records its expected date once
  // the block takes it.
  task automatic send_word(input logic [31:0] secs);
    conversion_t c;
    @(negedge clk);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid <= 1'b1;
    epoch_seconds <= secs;
    do @(posedge clk); while (in_stall);
    c.secs = secs;
    c.date = calendar_of(secs);
    dates_due.push_back(c);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (dates_due.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    conversion_t c;
    if (!rst && out_valid && !out_stall) begin
      if (dates_due.size() == 0) begin
        report_mismatch($sformatf("unexpected word %0d-%0d-%0d %0d:%0d:%0d",
                                  year_number, month_number, day_of_month,
                                  hour_of_day, minute_of_hour, second_of_minute));
      end else begin
        c = dates_due.pop_front();
        check_field("day_of_month", c.secs, 32'(day_of_month),
                    32'(c.date.day_of_month));
        check_field("month_number", c.secs, 32'(month_number),
                    32'(c.date.month_number));
        check_field("year_number", c.secs, 32'(year_number),
                    32'(c.date.year_number));
        check_field("hour_of_day", c.secs, 32'(hour_of_day),
                    32'(c.date.hour_of_day));
        check_field("minute_of_hour", c.secs, 32'(minute_of_hour),
                    32'(c.date.minute_of_hour));
        check_field("second_of_minute", c.secs, 32'(second_of_minute),
                    32'(c.date.second_of_minute));
      end
    end
  end

  initial begin : receiver
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
        out_stall <= 1'b0;
      end else if (idling_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Test completed with failures");
    $finish;
  end

  // Field extremes, day, month and year edges, leap and non-leap Februaries, and the last input.
  task automatic test_corners();
    logic [31:0] corners[] = '{
      32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
      32'd2678399, 32'd2678400, 32'd31535999, 32'd31536000, 32'd68169599,
      32'd68169600, 32'd68255999, 32'd68256000, 32'd951782400, 32'd978307199,
      32'd4107542399, 32'd4107542400, 32'd2147483647, 32'd2147483648,
      32'hAAAAAAAA, 32'h55555555, 32'hFFFFFFFF
    };
    foreach (corners[i]) send_word(corners[i]);
    wait_drained();
  endtask

  // The receiver holds off while words keep coming, so the block fills and stalls its input.
  task automatic test_backpressure();
    hold_request = 1'b1;
    repeat (6) send_word($urandom_range(0, 200 * SECS_PER_DAY));
    wait_drained();
  endtask

  // Partly uniform timestamps, with many on day edges, near the start and near the top.
  task automatic test_random(input int count);
    logic [31:0] secs;
    int          pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        secs = $urandom;
      end else if (pick < 7) begin
        secs = $urandom_range(0, 49710) * SECS_PER_DAY;
        if ($urandom_range(0, 1) == 1) begin
          secs = secs - 1;
        end
      end else if (pick < 9) begin
        secs = $urandom_range(0, 5 * 366 * SECS_PER_DAY);
      end else begin
        secs = 32'hFFFFFFFF - $urandom_range(0, 32'h00FFFFFF);
      end
      send_word(secs);
      if (n % 200 == 199) begin
        wait_drained();
      end
    end
    wait_drained();
  endtask

  task automatic test_streaming(input int count);
    idling_on = 1'b0;
    repeat (count) send_word($urandom);
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    epoch_seconds = 32'd0;
    out_stall = 1'b0;
    mismatch_count = 0;
    idling_on = 1'b1;
    hold_request = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_corners();
    test_backpressure();
    test_random(600);
    test_streaming(40);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (dates_due.size() != 0) begin
      report_mismatch($sformatf("%0d words never came out", dates_due.size()));
    end
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ustcd_pkg.sv
rtl/ustcd_sub.sv
rtl/ustcd_seq.sv
rtl/unix_seconds_to_calendar_date_top.sv
verif/unix_seconds_to_calendar_date_top_test.sv
